/* hw/rtl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// Banker's safety check package
// Shared field widths, command and register codes, and the queue word that
// the front end hands to the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

   // Default sizing of the tables
   localparam int DEF_MAX_PROCESSES = 8;
   localparam int DEF_MAX_RESOURCES = 4;
   localparam int DEF_COUNT_BITS    = 8;

   // Port field widths
   localparam int CMD_W       = 2;
   localparam int PIDX_IN_W   = 3;
   localparam int RIDX_IN_W   = 2;
   localparam int AMOUNT_W    = 8;
   localparam int PID_OUT_W   = 3;
   localparam int PCOUNT_W    = 4;
   localparam int RCOUNT_W    = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   // Depth of the command queue between front end and engine (power of two)
   localparam int QUEUE_DEPTH = 2;

   // Command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_LOAD_ROW   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_AVAIL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK      = 2'd2;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_COUNT  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESOURCE_COUNT = 1'd1;

   // Register reset values
   localparam logic [PCOUNT_W-1:0] PROCESS_COUNT_RESET  = 4'd5;
   localparam logic [RCOUNT_W-1:0] RESOURCE_COUNT_RESET = 3'd3;

   // Decoded operation kinds
   typedef enum logic [1:0] {
      OP_LOAD_ROW,
      OP_LOAD_AVAIL,
      OP_CHECK
   } op_kind_type;

   // One queued operation
   typedef struct packed {
      op_kind_type           kind;
      logic [PIDX_IN_W-1:0]  process_index;
      logic [RIDX_IN_W-1:0]  resource_index;
      logic [AMOUNT_W-1:0]   allocated;
      logic [AMOUNT_W-1:0]   maximum;
      logic [AMOUNT_W-1:0]   available_amount;
   } op_type;

   // Engine sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } engine_state_type;

endpackage

`default_nettype wire

/* hw/rtl/bankers_safety_check.sv */
// ----------------------------------------------------------------------------
// Banker's safety check
// Deadlock-avoidance safety check over loaded allocation, maximum and
// available tables.
// ----------------------------------------------------------------------------
// Usage:
//   req_* words carry a command: load one allocation/maximum entry, load one
//   available amount, or run a check. Loads give no response. A check gives
//   process_count (clamped to 1..MAX_PROCESSES) rsp_* words (safe order,
//   is_safe high, last on the final one) or one word with is_safe low, last high.
//   csr_write sets process_count (index 0) or resource_count (index 1);
//   write them only while no check is in flight.
//   Flow: a word waits in a two-entry queue; the engine takes the queue
//   head while idle and retires a load without a response. A check first
//   copies the available vector into the pool, then scans one process per
//   cycle, pass by pass, until every process has finished or the last pass
//   ends, then emits its result words as rsp_ready allows; the scan rate
//   is set by the single table read port and the pool update loop.
//   Reset clears the queue, the result valid flag and the scan state and sets
//   process_count to 5 and resource_count to 3; tables are undefined until
//   loaded. No clearing pass follows reset.
//   A stalled rsp_ready holds the result register and the check in place;
//   req_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_safety_check #(
   parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES,
   parameter int COUNT_BITS    = bsc_pkg::DEF_COUNT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bsc_pkg::CMD_W-1:0]       req_command,
   input  logic [bsc_pkg::PIDX_IN_W-1:0]   req_process_index,
   input  logic [bsc_pkg::RIDX_IN_W-1:0]   req_resource_index,
   input  logic [bsc_pkg::AMOUNT_W-1:0]    req_allocated,
   input  logic [bsc_pkg::AMOUNT_W-1:0]    req_maximum,
   input  logic [bsc_pkg::AMOUNT_W-1:0]    req_available_amount,
   input  logic                            csr_write,
   input  logic [bsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bsc_pkg::PID_OUT_W-1:0]   rsp_process_id,
   output logic                            rsp_is_safe,
   output logic                            rsp_last
);

   import bsc_pkg::*;

   logic [PCOUNT_W-1:0] process_count_ff;
   logic [RCOUNT_W-1:0] resource_count_ff;
   logic                op_valid;
   op_type              op;
   logic                op_pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         process_count_ff  <= PROCESS_COUNT_RESET;
         resource_count_ff <= RESOURCE_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PROCESS_COUNT: begin
               process_count_ff <= csr_data[PCOUNT_W-1:0];
            end
            CSR_RESOURCE_COUNT: begin
               resource_count_ff <= csr_data[RCOUNT_W-1:0];
            end
            default: begin
               process_count_ff <= process_count_ff;
            end
         endcase
      end
   end

   bsc_front #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_process_index    (req_process_index),
      .req_resource_index   (req_resource_index),
      .req_allocated        (req_allocated),
      .req_maximum          (req_maximum),
      .req_available_amount (req_available_amount),
      .op_valid             (op_valid),
      .op                   (op),
      .op_pop               (op_pop)
   );

   bsc_engine #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .process_count  (process_count_ff),
      .resource_count (resource_count_ff),
      .op_valid       (op_valid),
      .op             (op),
      .op_pop         (op_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_process_id (rsp_process_id),
      .rsp_is_safe    (rsp_is_safe),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

/* hw/rtl/bsc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/bsc_front.sv */
// ----------------------------------------------------------------------------
// Banker's safety check front end
// Accepts request words, drops unused commands and out-of-range loads, and
// queues the rest for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_front #(
   parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bsc_pkg::CMD_W-1:0]      req_command,
   input  logic [bsc_pkg::PIDX_IN_W-1:0]  req_process_index,
   input  logic [bsc_pkg::RIDX_IN_W-1:0]  req_resource_index,
   input  logic [bsc_pkg::AMOUNT_W-1:0]   req_allocated,
   input  logic [bsc_pkg::AMOUNT_W-1:0]   req_maximum,
   input  logic [bsc_pkg::AMOUNT_W-1:0]   req_available_amount,
   output logic                           op_valid,
   output bsc_pkg::op_type                op,
   input  logic                           op_pop
);

   import bsc_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type              word;
   logic                keep;
   logic                push;
   op_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   // Classify the incoming word; drop what has no effect
   always_comb begin
      word.kind             = OP_CHECK;
      word.process_index    = req_process_index;
      word.resource_index   = req_resource_index;
      word.allocated        = req_allocated;
      word.maximum          = req_maximum;
      word.available_amount = req_available_amount;
      keep                  = 1'b0;
      unique case (req_command)
         CMD_LOAD_ROW: begin
            word.kind = OP_LOAD_ROW;
            keep      = (int'(req_process_index) < MAX_PROCESSES) &&
                        (int'(req_resource_index) < MAX_RESOURCES);
         end
         CMD_LOAD_AVAIL: begin
            word.kind = OP_LOAD_AVAIL;
            keep      = int'(req_resource_index) < MAX_RESOURCES;
         end
         CMD_CHECK: begin
            word.kind = OP_CHECK;
            keep      = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready && keep;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = op_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !op_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && op_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued words
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= word;
      end
   end

   assign op_valid = (count_ff != '0);
   assign op       = queue_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* hw/rtl/bsc_engine.sv */
// ----------------------------------------------------------------------------
// Banker's safety check engine
// Holds the allocation and maximum tables and the available vector, runs
// the pass-by-pass safety scan one process per cycle, and drives the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_engine #(
   parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES,
   parameter int COUNT_BITS    = bsc_pkg::DEF_COUNT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bsc_pkg::PCOUNT_W-1:0]   process_count,
   input  logic [bsc_pkg::RCOUNT_W-1:0]   resource_count,
   input  logic                           op_valid,
   input  bsc_pkg::op_type                op,
   output logic                           op_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bsc_pkg::PID_OUT_W-1:0]  rsp_process_id,
   output logic                           rsp_is_safe,
   output logic                           rsp_last
);

   import bsc_pkg::*;

   localparam int PIDX_W = $clog2(MAX_PROCESSES);
   localparam int PCNT_W = $clog2(MAX_PROCESSES + 1);
   localparam int RCNT_W = $clog2(MAX_RESOURCES + 1);
   localparam int POOL_W = COUNT_BITS + PCNT_W;
   localparam int ROW_W  = 2 * COUNT_BITS;

   engine_state_type      state_ff;
   engine_state_type      state_in;

   logic [PCNT_W-1:0]     np;
   logic [RCNT_W-1:0]     nr;
   logic [PIDX_W-1:0]     np_last_idx;

   logic [PIDX_W-1:0]     p_ff;
   logic [PIDX_W-1:0]     p_next;
   logic [PIDX_W-1:0]     pass_ff;
   logic [PCNT_W-1:0]     done_ff;
   logic [POOL_W-1:0]     pool_ff [MAX_RESOURCES];
   logic [MAX_PROCESSES-1:0] fin_ff;
   logic [PIDX_W-1:0]     seq_ff  [MAX_PROCESSES];
   logic [COUNT_BITS-1:0] avail_ff [MAX_RESOURCES];

   logic                  rsp_valid_ff;
   logic [PID_OUT_W-1:0]  rsp_pid_ff;
   logic                  rsp_safe_ff;
   logic                  rsp_last_ff;

   logic                  check_start;
   logic                  load_row_go;
   logic                  load_avail_go;
   logic                  rsp_load;
   logic [PIDX_W-1:0]     rd_row;
   logic [PIDX_W-1:0]     wr_row;
   logic [ROW_W-1:0]      wr_data;
   logic [MAX_RESOURCES-1:0] col_wr;
   logic [ROW_W-1:0]      col_rd  [MAX_RESOURCES];

   logic [COUNT_BITS-1:0] need    [MAX_RESOURCES];
   logic [POOL_W-1:0]     pool_sum [MAX_RESOURCES];
   logic [MAX_RESOURCES-1:0] col_fits;
   logic                  fits;
   logic                  scan_all_done;
   logic                  scan_last;
   logic                  scan_end;
   logic                  safe;
   logic                  out_free;
   logic                  emit_end;

   // Clamp the counts to between one and the table sizes
   always_comb begin
      if (process_count == '0) begin
         np = PCNT_W'(1);
      end else if (int'(process_count) > MAX_PROCESSES) begin
         np = PCNT_W'(MAX_PROCESSES);
      end else begin
         np = PCNT_W'(process_count);
      end
      if (resource_count == '0) begin
         nr = RCNT_W'(1);
      end else if (int'(resource_count) > MAX_RESOURCES) begin
         nr = RCNT_W'(MAX_RESOURCES);
      end else begin
         nr = RCNT_W'(resource_count);
      end
   end

   assign np_last_idx = PIDX_W'(np - PCNT_W'(1));
   assign p_next      = (p_ff == np_last_idx) ? '0 : p_ff + PIDX_W'(1);

   // One table column per resource: allocation in the upper half
   assign wr_row  = PIDX_W'(op.process_index);
   assign wr_data = {COUNT_BITS'(op.allocated), COUNT_BITS'(op.maximum)};

   for (genvar g = 0; g < MAX_RESOURCES; g++) begin : g_col
      assign col_wr[g] = load_row_go && (int'(op.resource_index) == g);

      bsc_ram #(
         .WIDTH (ROW_W),
         .DEPTH (MAX_PROCESSES)
      ) u_ram (
         .clock   (clock),
         .wr_en   (col_wr[g]),
         .wr_addr (wr_row),
         .wr_data (wr_data),
         .rd_addr (rd_row),
         .rd_data (col_rd[g])
      );
   end

   // Compare each column's need against the pool, in parallel
   always_comb begin
      for (int r = 0; r < MAX_RESOURCES; r++) begin
         need[r] = (col_rd[r][COUNT_BITS-1:0] > col_rd[r][ROW_W-1:COUNT_BITS]) ?
                   col_rd[r][COUNT_BITS-1:0] - col_rd[r][ROW_W-1:COUNT_BITS] : '0;
         pool_sum[r] = pool_ff[r] + POOL_W'(col_rd[r][ROW_W-1:COUNT_BITS]);
         col_fits[r] = (r >= int'(nr)) || (POOL_W'(need[r]) <= pool_ff[r]);
      end
   end

   assign fits          = !fin_ff[p_ff] && (&col_fits);
   assign scan_all_done = fits && ((done_ff + PCNT_W'(1)) == np);
   assign scan_last     = (p_ff == np_last_idx) && (pass_ff == np_last_idx);
   assign scan_end      = scan_all_done || scan_last;
   assign safe          = (done_ff == np);
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign emit_end      = out_free && (!safe || (p_ff == np_last_idx));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid && (op.kind == OP_CHECK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      check_start   = 1'b0;
      load_row_go   = 1'b0;
      load_avail_go = 1'b0;
      op_pop        = 1'b0;
      rsp_load      = 1'b0;
      rd_row        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               unique case (op.kind)
                  OP_LOAD_ROW: begin
                     load_row_go = 1'b1;
                     op_pop      = 1'b1;
                  end
                  OP_LOAD_AVAIL: begin
                     load_avail_go = 1'b1;
                     op_pop        = 1'b1;
                  end
                  OP_CHECK: begin
                     check_start = 1'b1;
                  end
                  default: begin
                     op_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_row = p_next;
         end
         ST_EMIT: begin
            rsp_load = out_free;
            op_pop   = emit_end;
         end
         default: begin
            rd_row = '0;
         end
      endcase
   end

   // Control state: scan position, pool, finished flags, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p_ff         <= '0;
         pass_ff      <= '0;
         done_ff      <= '0;
         fin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < MAX_RESOURCES; r++) begin
            pool_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (check_start) begin
            p_ff    <= '0;
            pass_ff <= '0;
            done_ff <= '0;
            fin_ff  <= '0;
            for (int r = 0; r < MAX_RESOURCES; r++) begin
               pool_ff[r] <= POOL_W'(avail_ff[r]);
            end
         end else if (state_ff == ST_SCAN) begin
            if (fits) begin
               fin_ff[p_ff] <= 1'b1;
               done_ff      <= done_ff + PCNT_W'(1);
               for (int r = 0; r < MAX_RESOURCES; r++) begin
                  if (r < int'(nr)) begin
                     pool_ff[r] <= pool_sum[r];
                  end
               end
            end
            if (scan_end) begin
               p_ff <= '0;
            end else if (p_ff == np_last_idx) begin
               p_ff    <= '0;
               pass_ff <= pass_ff + PIDX_W'(1);
            end else begin
               p_ff <= p_ff + PIDX_W'(1);
            end
         end else if ((state_ff == ST_EMIT) && out_free && !emit_end) begin
            p_ff <= p_ff + PIDX_W'(1);
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: available vector, safe sequence, result word
   always_ff @(posedge clock) begin
      if (load_avail_go) begin
         for (int r = 0; r < MAX_RESOURCES; r++) begin
            if (int'(op.resource_index) == r) begin
               avail_ff[r] <= COUNT_BITS'(op.available_amount);
            end
         end
      end
      if ((state_ff == ST_SCAN) && fits) begin
         seq_ff[done_ff[PIDX_W-1:0]] <= p_ff;
      end
      if (rsp_load) begin
         if (safe) begin
            rsp_pid_ff  <= PID_OUT_W'(seq_ff[p_ff]);
            rsp_safe_ff <= 1'b1;
            rsp_last_ff <= (p_ff == np_last_idx);
         end else begin
            rsp_pid_ff  <= '0;
            rsp_safe_ff <= 1'b0;
            rsp_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_process_id = rsp_pid_ff;
   assign rsp_is_safe    = rsp_safe_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire
